@@ hdl/lsm_pkg.sv @@
// Shared types, constants and helpers for the line substring matcher.
`default_nettype none
package lsm_pkg;

	localparam int MAX_LINE    = 1024;
	localparam int MAX_PATTERN = 8;
	localparam int WINDOW      = 8;
	localparam int LINE_W      = $clog2(MAX_LINE);
	localparam int POS_W       = 10;
	localparam int CNT_W       = 16;
	localparam int PLEN_W      = 4;
	localparam int PAT_W       = 64;
	localparam int CFG_IDX_W   = 1;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

	localparam logic [PAT_W-1:0]  PATTERN_RESET = 64'h0000_0064_6C75_6F77;
	localparam logic [PLEN_W-1:0] LENGTH_RESET  = 4'd5;
	localparam logic [7:0]        CHAR_NL       = 8'd10;
	localparam logic [7:0]        CHAR_NUL      = 8'd0;

	typedef struct packed {
		logic       eos;
		logic       nul;
		logic       nl;
		logic [7:0] ch;
	} lsm_entry_t;

	typedef struct packed {
		logic [PAT_W-1:0]  bytes;
		logic [PLEN_W-1:0] length;
	} lsm_cfg_t;

	function automatic logic [PLEN_W-1:0] eff_length(input lsm_cfg_t cfg);
		logic [PLEN_W-1:0] n;
		logic [PLEN_W-1:0] res;
		logic              stop;
		n = cfg.length;
		if (n > PLEN_W'(MAX_PATTERN)) begin
			n = PLEN_W'(MAX_PATTERN);
		end
		if (n > PLEN_W'(WINDOW)) begin
			n = PLEN_W'(WINDOW);
		end
		res  = n;
		stop = 1'b0;
		for (int k = 0; k < WINDOW; k++) begin
			if (!stop && PLEN_W'(k) < n && cfg.bytes[8*k +: 8] == CHAR_NUL) begin
				res  = PLEN_W'(k);
				stop = 1'b1;
			end
		end
		return res;
	endfunction

endpackage
`default_nettype wire

@@ hdl/line_substring_matcher_top.sv @@
// Top level of the line substring matcher: config registers and stage wiring.
// A byte request passes the front register and the queue, then the result register.
// Throughput, when not stalled: one request in and one queue entry retired per cycle.
// A four-entry queue lets the front keep accepting while a result waits on out_stall.
// Reset: asynchronous, active low; clears line state, count and queue; pattern
// returns to "would" with length 5.
`default_nettype none
module line_substring_matcher_top import lsm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [PAT_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           char_in,
	input  wire logic                 end_of_stream,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      line_matched,
	output logic [POS_W-1:0]          match_position,
	output logic [POS_W-1:0]          line_length,
	output logic [CNT_W-1:0]          matched_lines
);

	lsm_cfg_t   cfg_q;
	lsm_entry_t push_entry;
	lsm_entry_t head;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bytes  <= PATTERN_RESET;
			cfg_q.length <= LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATTERN_BYTES:  cfg_q.bytes  <= cfg_data;
				CFG_PATTERN_LENGTH: cfg_q.length <= cfg_data[PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	lsm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_in       (char_in),
		.end_of_stream (end_of_stream),
		.q_full        (full),
		.q_push        (push),
		.q_entry       (push_entry)
	);

	lsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.head       (head)
	);

	lsm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_empty        (empty),
		.q_head         (head),
		.q_pop          (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.line_matched   (line_matched),
		.match_position (match_position),
		.line_length    (line_length),
		.matched_lines  (matched_lines)
	);

endmodule
`default_nettype wire

@@ hdl/lsm_front.sv @@
// Front stage: accepts input requests and classifies each byte.
`default_nettype none
module lsm_front import lsm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] char_in,
	input  wire logic       end_of_stream,
	input  wire logic       q_full,
	output logic            q_push,
	output lsm_entry_t      q_entry
);

	logic       valid_s1;
	lsm_entry_t entry_s1;
	logic       accept;

	assign q_push   = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_entry  = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1.eos <= end_of_stream;
			entry_s1.nul <= (char_in == CHAR_NUL);
			entry_s1.nl  <= (char_in == CHAR_NL);
			entry_s1.ch  <= char_in;
		end
	end

endmodule
`default_nettype wire

@@ hdl/lsm_queue.sv @@
// Short request queue between front and back stages.
`default_nettype none
module lsm_queue import lsm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire lsm_entry_t push_entry,
	output logic            full,
	input  wire logic       pop,
	output logic            empty,
	output lsm_entry_t      head
);

	lsm_entry_t         mem_q [QDEPTH];
	logic [QAW-1:0]     wptr_q;
	logic [QAW-1:0]     rptr_q;
	logic [QAW:0]       count_q;

	assign full  = (count_q == (QAW+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

@@ hdl/lsm_back.sv @@
// Back stage: line tracking, window compare and result register.
`default_nettype none
module lsm_back import lsm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lsm_cfg_t    cfg,
	input  wire logic        q_empty,
	input  wire lsm_entry_t  q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             line_matched,
	output logic [POS_W-1:0] match_position,
	output logic [POS_W-1:0] line_length,
	output logic [CNT_W-1:0] matched_lines
);

	logic [7:0]        win_q [WINDOW];
	logic [7:0]        win_n [WINDOW];
	logic [LINE_W-1:0] pos_q;
	logic [LINE_W-1:0] pos_inc;
	logic [LINE_W-1:0] first_q;
	logic              found_q;
	logic              nul_q;
	logic              nul_n;
	logic [CNT_W-1:0]  cnt_q;
	logic [PLEN_W-1:0] len;
	logic [WINDOW:0]   len_hit;
	logic              hit;
	logic              found_n;
	logic [LINE_W-1:0] first_n;
	logic              finish;
	logic              out_valid_q;
	logic              matched_q;
	logic [POS_W-1:0]  mpos_q;
	logic [POS_W-1:0]  llen_q;
	logic [CNT_W-1:0]  cnt_next;

	assign q_pop   = !q_empty && (!out_valid_q || !out_stall);
	assign len     = eff_length(cfg);
	assign pos_inc = pos_q + 1'b1;
	assign nul_n   = nul_q || q_head.nul;

	always_comb begin
		win_n[0] = q_head.ch;
		for (int k = 1; k < WINDOW; k++) begin
			win_n[k] = win_q[k-1];
		end
	end

	always_comb begin
		len_hit = '0;
		for (int l = 1; l <= WINDOW; l++) begin
			len_hit[l] = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (win_n[l-1-k] != cfg.bytes[8*k +: 8]) begin
					len_hit[l] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		hit = !found_q && !nul_n && len != '0 && pos_inc >= LINE_W'(len)
			&& len_hit[len[$clog2(WINDOW+1)-1:0]];
		found_n = q_head.eos ? found_q : (found_q || hit);
		first_n = hit ? (pos_inc - LINE_W'(len)) : first_q;
		if (q_head.eos) begin
			finish = (pos_q != '0);
		end else begin
			finish = q_head.nl || (pos_inc >= LINE_W'(MAX_LINE - 1));
		end
		cnt_next = cnt_q;
		if (found_n && cnt_q != '1) begin
			cnt_next = cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW; k++) begin
				win_q[k] <= '0;
			end
			pos_q       <= '0;
			first_q     <= '0;
			found_q     <= 1'b0;
			nul_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (finish) begin
					for (int k = 0; k < WINDOW; k++) begin
						win_q[k] <= '0;
					end
					pos_q       <= '0;
					first_q     <= '0;
					found_q     <= 1'b0;
					nul_q       <= 1'b0;
					cnt_q       <= cnt_next;
				end else if (!q_head.eos) begin
					if (!nul_n) begin
						for (int k = 0; k < WINDOW; k++) begin
							win_q[k] <= win_n[k];
						end
					end
					pos_q   <= pos_inc;
					first_q <= first_n;
					found_q <= found_n;
					nul_q   <= nul_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && finish) begin
			matched_q <= found_n;
			mpos_q    <= found_n ? POS_W'(first_n) : '0;
			llen_q    <= q_head.eos ? POS_W'(pos_q) : POS_W'(pos_inc);
		end
	end

	assign out_valid      = out_valid_q;
	assign line_matched   = matched_q;
	assign match_position = mpos_q;
	assign line_length    = llen_q;
	assign matched_lines  = cnt_q;

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> llen_q != '0)
		else $error("line result with zero length");

	a_nomatch_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !matched_q |-> mpos_q == '0)
		else $error("position set on unmatched line");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < LINE_W'(MAX_LINE - 1))
		else $error("line position past limit");

	a_first_bound: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> first_q < pos_q)
		else $error("first match beyond line position");

	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q >= $past(cnt_q))
		else $error("matched line count decreased");

endmodule
`default_nettype wire
